// ----- design/qrv_pkg.sv -----
// Shared widths, pipeline sizes and stage types for the quaternion vector rotator.
`default_nettype none
package qrv_pkg;

   localparam int DATA_W      = 16;
   localparam int NUM_QUAT    = 4;
   localparam int NUM_VEC     = 3;
   localparam int IN_TDATA_W  = (NUM_QUAT + NUM_VEC) * DATA_W;
   localparam int OUT_TDATA_W = NUM_VEC * DATA_W;
   localparam int OUT_USER_W  = 2;
   localparam int USER_ERR    = 0;
   localparam int USER_SAT    = 1;

   localparam int PROD_W = 2 * DATA_W;
   localparam int P1_W   = PROD_W + 2;
   localparam int P3_W   = P1_W + DATA_W;
   localparam int P2_W   = P3_W + 2;
   localparam int NRM_W  = PROD_W + 1;
   localparam int REM_W  = P2_W;
   localparam int QUO_W  = DATA_W + 1;

   localparam int FRONT_STG = 6;
   localparam int NUM_STG   = FRONT_STG + QUO_W + 1;

   localparam logic [QUO_W-1:0] SAT_POS = QUO_W'((2 ** (DATA_W - 1)) - 1);
   localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(2 ** (DATA_W - 1));
   localparam logic [DATA_W-1:0] OUT_MAX = DATA_W'((2 ** (DATA_W - 1)) - 1);
   localparam logic [DATA_W-1:0] OUT_MIN = DATA_W'(2 ** (DATA_W - 1));

   typedef struct packed {
      logic [NUM_VEC-1:0][REM_W-1:0] rem;
      logic [NUM_VEC-1:0][QUO_W-1:0] quo;
      logic [NUM_VEC-1:0]            neg;
      logic [NRM_W-1:0]              den;
      logic                          zero;
   } div_stage_type;

endpackage
`default_nettype wire

// ----- design/qrv_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor.
`default_nettype none
module qrv_divider (
   input  wire logic                       clock,
   input  wire logic [qrv_pkg::QUO_W-1:0]  stage_en,
   input  wire qrv_pkg::div_stage_type     din,
   output qrv_pkg::div_stage_type          dout
);

   qrv_pkg::div_stage_type step_ff [qrv_pkg::QUO_W];
   qrv_pkg::div_stage_type step_in [qrv_pkg::QUO_W];
   qrv_pkg::div_stage_type src     [qrv_pkg::QUO_W];

   for (genvar s = 0; s < qrv_pkg::QUO_W; s++) begin : g_step
      localparam int BIT = qrv_pkg::QUO_W - 1 - s;

      if (s == 0) begin : g_first
         assign src[s] = din;
      end else begin : g_next
         assign src[s] = step_ff[s-1];
      end

      always_comb begin
         logic [qrv_pkg::REM_W-1:0] shifted;
         logic                      ge;
         shifted = qrv_pkg::REM_W'(src[s].den) << BIT;
         step_in[s] = src[s];
         for (int l = 0; l < qrv_pkg::NUM_VEC; l++) begin
            ge = src[s].rem[l] >= shifted;
            step_in[s].rem[l] = ge ? src[s].rem[l] - shifted : src[s].rem[l];
            step_in[s].quo[l] = {src[s].quo[l][qrv_pkg::QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            step_ff[s] <= step_in[s];
         end
      end
   end

   assign dout = step_ff[qrv_pkg::QUO_W-1];

endmodule
`default_nettype wire

// ----- design/quaternion_rotate_vector.sv -----
// Quaternion vector rotation q*v*inverse(q), Q2.14, fully pipelined top level.
//
//  channel  dir  tdata (low bit up)                                  tuser
//  req      in   quat_w quat_x quat_y quat_z vec_x vec_y vec_z       -
//  rsp      out  rot_x rot_y rot_z                                   zero_quat_error saturated
//
// Pipeline: six front stages (capture and arithmetic), 17 divider stages (one quotient bit each),
// one output register. One request per cycle sustained while rsp_tready stays high.
// Reset clears the valid bits only; the data path needs none.
// A stall holds the stages that are full from the output back; empty stages
// ahead of it keep filling, so requests are taken while a result waits.
`default_nettype none
module quaternion_rotate_vector (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
   input  wire logic [qrv_pkg::IN_TDATA_W-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [qrv_pkg::OUT_TDATA_W-1:0]          rsp_tdata,
   // zero_quat_error, saturated
   output logic [qrv_pkg::OUT_USER_W-1:0]           rsp_tuser
);

   localparam int DW = qrv_pkg::DATA_W;
   localparam int NS = qrv_pkg::NUM_STG;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NS-1];

   // stage 0: capture
   logic signed [DW-1:0] q0_ff [qrv_pkg::NUM_QUAT];
   logic signed [DW-1:0] x0_ff [qrv_pkg::NUM_VEC];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < qrv_pkg::NUM_QUAT; i++) begin
            q0_ff[i] <= req_tdata[i*DW +: DW];
         end
         for (int i = 0; i < qrv_pkg::NUM_VEC; i++) begin
            x0_ff[i] <= req_tdata[(qrv_pkg::NUM_QUAT + i)*DW +: DW];
         end
      end
   end

   // stage 1: q*v products and squares
   logic signed [qrv_pkg::PROD_W-1:0] m1_ff [12];
   logic signed [qrv_pkg::PROD_W-1:0] m1_in [12];
   logic signed [qrv_pkg::PROD_W-1:0] sq1_ff [qrv_pkg::NUM_QUAT];
   logic signed [qrv_pkg::PROD_W-1:0] sq1_in [qrv_pkg::NUM_QUAT];
   logic signed [DW-1:0]              q1_ff [qrv_pkg::NUM_QUAT];

   always_comb begin
      m1_in[0]  = q0_ff[1] * x0_ff[0];
      m1_in[1]  = q0_ff[2] * x0_ff[1];
      m1_in[2]  = q0_ff[3] * x0_ff[2];
      m1_in[3]  = q0_ff[0] * x0_ff[0];
      m1_in[4]  = q0_ff[2] * x0_ff[2];
      m1_in[5]  = q0_ff[3] * x0_ff[1];
      m1_in[6]  = q0_ff[0] * x0_ff[1];
      m1_in[7]  = q0_ff[3] * x0_ff[0];
      m1_in[8]  = q0_ff[1] * x0_ff[2];
      m1_in[9]  = q0_ff[0] * x0_ff[2];
      m1_in[10] = q0_ff[1] * x0_ff[1];
      m1_in[11] = q0_ff[2] * x0_ff[0];
      for (int i = 0; i < qrv_pkg::NUM_QUAT; i++) begin
         sq1_in[i] = q0_ff[i] * q0_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         m1_ff  <= m1_in;
         sq1_ff <= sq1_in;
         q1_ff  <= q0_ff;
      end
   end

   // stage 2: first Hamilton product and squared norm
   logic signed [qrv_pkg::P1_W-1:0]  a2_ff [qrv_pkg::NUM_QUAT];
   logic signed [qrv_pkg::P1_W-1:0]  a2_in [qrv_pkg::NUM_QUAT];
   logic        [qrv_pkg::NRM_W-1:0] n2_ff;
   logic        [qrv_pkg::NRM_W-1:0] n2_in;
   logic signed [DW-1:0]             q2_ff [qrv_pkg::NUM_QUAT];

   always_comb begin
      a2_in[0] = -(qrv_pkg::P1_W'(m1_ff[0]) + qrv_pkg::P1_W'(m1_ff[1])
                   + qrv_pkg::P1_W'(m1_ff[2]));
      a2_in[1] = qrv_pkg::P1_W'(m1_ff[3]) + qrv_pkg::P1_W'(m1_ff[4])
                 - qrv_pkg::P1_W'(m1_ff[5]);
      a2_in[2] = qrv_pkg::P1_W'(m1_ff[6]) + qrv_pkg::P1_W'(m1_ff[7])
                 - qrv_pkg::P1_W'(m1_ff[8]);
      a2_in[3] = qrv_pkg::P1_W'(m1_ff[9]) + qrv_pkg::P1_W'(m1_ff[10])
                 - qrv_pkg::P1_W'(m1_ff[11]);
      n2_in = '0;
      for (int i = 0; i < qrv_pkg::NUM_QUAT; i++) begin
         n2_in = n2_in + qrv_pkg::NRM_W'($unsigned(sq1_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         a2_ff <= a2_in;
         n2_ff <= n2_in;
         q2_ff <= q1_ff;
      end
   end

   // stage 3: products with the conjugate
   logic signed [qrv_pkg::P3_W-1:0]  k3_ff [12];
   logic signed [qrv_pkg::P3_W-1:0]  k3_in [12];
   logic        [qrv_pkg::NRM_W-1:0] n3_ff;

   always_comb begin
      k3_in[0]  = a2_ff[0] * q2_ff[1];
      k3_in[1]  = a2_ff[1] * q2_ff[0];
      k3_in[2]  = a2_ff[2] * q2_ff[3];
      k3_in[3]  = a2_ff[3] * q2_ff[2];
      k3_in[4]  = a2_ff[0] * q2_ff[2];
      k3_in[5]  = a2_ff[2] * q2_ff[0];
      k3_in[6]  = a2_ff[3] * q2_ff[1];
      k3_in[7]  = a2_ff[1] * q2_ff[3];
      k3_in[8]  = a2_ff[0] * q2_ff[3];
      k3_in[9]  = a2_ff[3] * q2_ff[0];
      k3_in[10] = a2_ff[1] * q2_ff[2];
      k3_in[11] = a2_ff[2] * q2_ff[1];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         k3_ff <= k3_in;
         n3_ff <= n2_ff;
      end
   end

   // stage 4: vector part of the second product
   logic signed [qrv_pkg::P2_W-1:0]  s4_ff [qrv_pkg::NUM_VEC];
   logic signed [qrv_pkg::P2_W-1:0]  s4_in [qrv_pkg::NUM_VEC];
   logic        [qrv_pkg::NRM_W-1:0] n4_ff;

   always_comb begin
      for (int l = 0; l < qrv_pkg::NUM_VEC; l++) begin
         s4_in[l] = -qrv_pkg::P2_W'(k3_ff[4*l]) + qrv_pkg::P2_W'(k3_ff[4*l+1])
                    - qrv_pkg::P2_W'(k3_ff[4*l+2]) + qrv_pkg::P2_W'(k3_ff[4*l+3]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_ff <= s4_in;
         n4_ff <= n3_ff;
      end
   end

   // stage 5: sign and magnitude, rounding half added
   qrv_pkg::div_stage_type d5_ff;
   qrv_pkg::div_stage_type d5_in;
   qrv_pkg::div_stage_type dq;

   always_comb begin
      logic [qrv_pkg::REM_W-1:0] half;
      half = qrv_pkg::REM_W'(n4_ff >> 1);
      d5_in.den  = n4_ff;
      d5_in.zero = (n4_ff == '0);
      for (int l = 0; l < qrv_pkg::NUM_VEC; l++) begin
         d5_in.neg[l] = s4_ff[l][qrv_pkg::P2_W-1];
         d5_in.quo[l] = '0;
         d5_in.rem[l] = (d5_in.neg[l] ? $unsigned(-s4_ff[l]) : $unsigned(s4_ff[l])) + half;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         d5_ff <= d5_in;
      end
   end

   qrv_divider u_div (
      .clock    (clock),
      .stage_en (adv[qrv_pkg::FRONT_STG +: qrv_pkg::QUO_W]),
      .din      (d5_ff),
      .dout     (dq)
   );

   // output stage: sign, saturation, zero quaternion
   logic [DW-1:0] rot_ff [qrv_pkg::NUM_VEC];
   logic [DW-1:0] rot_in [qrv_pkg::NUM_VEC];
   logic          err_ff;
   logic          sat_ff;
   logic          sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int l = 0; l < qrv_pkg::NUM_VEC; l++) begin
         if (dq.zero) begin
            rot_in[l] = '0;
         end else if (!dq.neg[l] && dq.quo[l] > qrv_pkg::SAT_POS) begin
            rot_in[l] = qrv_pkg::OUT_MAX;
            sat_in    = 1'b1;
         end else if (dq.neg[l] && dq.quo[l] > qrv_pkg::SAT_NEG) begin
            rot_in[l] = qrv_pkg::OUT_MIN;
            sat_in    = 1'b1;
         end else if (dq.neg[l]) begin
            rot_in[l] = DW'(-dq.quo[l]);
         end else begin
            rot_in[l] = DW'(dq.quo[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         rot_ff <= rot_in;
         err_ff <= dq.zero;
         sat_ff <= sat_in;
      end
   end

   always_comb begin
      for (int l = 0; l < qrv_pkg::NUM_VEC; l++) begin
         rsp_tdata[l*DW +: DW] = rot_ff[l];
      end
      rsp_tuser[qrv_pkg::USER_ERR] = err_ff;
      rsp_tuser[qrv_pkg::USER_SAT] = sat_ff;
   end

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err_ff |-> rsp_tdata == '0 && !sat_ff)
      else $error("zero quaternion result not cleared");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted request lost at first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !rsp_tready |=> v_ff[NS-1] && $stable(rot_ff[0]) && $stable(sat_ff))
      else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- sim/quaternion_rotate_vector_test.sv -----
// Self-checking stream testbench for the quaternion vector rotator.
module quaternion_rotate_vector_test;

   localparam int DW = qrv_pkg::DATA_W;

   typedef struct packed {
      logic signed [DW-1:0] rot_z;
      logic signed [DW-1:0] rot_y;
      logic signed [DW-1:0] rot_x;
      logic                 saturated;
      logic                 zero_quat_error;
   } rotation_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [qrv_pkg::IN_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [qrv_pkg::OUT_TDATA_W-1:0] rsp_tdata;
   logic [qrv_pkg::OUT_USER_W-1:0] rsp_tuser;

   rotation_type rotations_due[$];
   int  errors;
   bit  quiet;
   bit  hold_rsp;

   quaternion_rotate_vector dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint sfield(logic [qrv_pkg::IN_TDATA_W-1:0] d, int idx);
      logic signed [DW-1:0] f;
      f = d[idx*DW +: DW];
      return longint'(f);
   endfunction

   function automatic logic [DW-1:0] round_clip(longint num, longint den, ref bit clip);
      longint mag;
      longint quo;
      mag = (num < 0) ? -num : num;
      quo = (mag + den / 2) / den;
      if (num >= 0 && quo > 32767) begin
         clip = 1'b1;
         return qrv_pkg::OUT_MAX;
      end
      if (num < 0 && quo > 32768) begin
         clip = 1'b1;
         return qrv_pkg::OUT_MIN;
      end
      return (num < 0) ? DW'(-quo) : DW'(quo);
   endfunction

   function automatic rotation_type rotate_vector(logic [qrv_pkg::IN_TDATA_W-1:0] d);
      longint q[4];
      longint c[4];
      longint v[4];
      longint a[4];
      longint b[4];
      longint n;
      bit clip;
      rotation_type r;
      for (int i = 0; i < 4; i++) q[i] = sfield(d, i);
      v[0] = 0;
      for (int i = 1; i < 4; i++) v[i] = sfield(d, i + 3);
      n = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
      r = '0;
      if (n == 0) begin
         r.zero_quat_error = 1'b1;
         return r;
      end
      c[0] = q[0];
      for (int i = 1; i < 4; i++) c[i] = -q[i];
      a[0] = q[0]*v[0] - q[1]*v[1] - q[2]*v[2] - q[3]*v[3];
      a[1] = q[0]*v[1] + v[0]*q[1] + q[2]*v[3] - q[3]*v[2];
      a[2] = q[0]*v[2] + v[0]*q[2] + q[3]*v[1] - q[1]*v[3];
      a[3] = q[0]*v[3] + v[0]*q[3] + q[1]*v[2] - q[2]*v[1];
      b[1] = a[0]*c[1] + c[0]*a[1] + a[2]*c[3] - a[3]*c[2];
      b[2] = a[0]*c[2] + c[0]*a[2] + a[3]*c[1] - a[1]*c[3];
      b[3] = a[0]*c[3] + c[0]*a[3] + a[1]*c[2] - a[2]*c[1];
      clip = 1'b0;
      r.rot_x = round_clip(b[1], n, clip);
      r.rot_y = round_clip(b[2], n, clip);
      r.rot_z = round_clip(b[3], n, clip);
      r.saturated = clip;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         rotations_due.push_back(rotate_vector(req_tdata));
   end

   always @(posedge clock) begin
      rotation_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rotations_due.size() == 0) begin
            $error("unexpected result %h %h", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = rotations_due.pop_front();
            if (rsp_tdata[0 +: DW] !== want.rot_x) begin
               $error("rot_x expected %h actual %h", want.rot_x, rsp_tdata[0 +: DW]);
               errors++;
            end
            if (rsp_tdata[DW +: DW] !== want.rot_y) begin
               $error("rot_y expected %h actual %h", want.rot_y,
                      rsp_tdata[DW +: DW]);
               errors++;
            end
            if (rsp_tdata[2*DW +: DW] !== want.rot_z) begin
               $error("rot_z expected %h actual %h", want.rot_z,
                      rsp_tdata[2*DW +: DW]);
               errors++;
            end
            if (rsp_tuser[qrv_pkg::USER_ERR] !== want.zero_quat_error) begin
               $error("zero_quat_error expected %b actual %b", want.zero_quat_error,
                      rsp_tuser[qrv_pkg::USER_ERR]);
               errors++;
            end
            if (rsp_tuser[qrv_pkg::USER_SAT] !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated,
                      rsp_tuser[qrv_pkg::USER_SAT]);
               errors++;
            end
         end
      end
   end

   // receiver: random idling, or a long counted hold-off on request
   always @(negedge clock) begin
      static int held = 0;
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         held++;
         if (held >= 300) begin
            hold_rsp = 1'b0;
            held = 0;
         end
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 19);
      end
   end

   task automatic send_request(input logic [DW-1:0] w, x, y, z, vx, vy, vz);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vy, vx, z, y, x, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [DW-1:0] pick_value(int mode);
      case (mode)
         0: return DW'($urandom);
         1: return DW'($urandom_range(16384) - 8192);
         2: return ($urandom_range(1)) ? qrv_pkg::OUT_MAX : qrv_pkg::OUT_MIN;
         default: return DW'($urandom_range(64) - 32);
      endcase
   endfunction

   task automatic test_directed();
      send_request(0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7fff);
      send_request(0, 0, 0, 0, 0, 0, 0);
      send_request(16384, 0, 0, 0, 16384, 16'hc000, 8192);
      send_request(11585, 0, 0, 11585, 16384, 0, 0);
      send_request(11585, 11585, 0, 0, 0, 16384, 0);
      send_request(0, 16384, 0, 0, 32767, 32767, 32767);
      send_request(3, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
      send_request(1, 1, 1, 1, 32767, 32767, 32767);
      send_request(1, 1, 1, 1, 16'h8000, 16'h8000, 16'h8000);
      send_request(32767, 32767, 32767, 32767, 32767, 16'h8000, 32767);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000);
      send_request(16'h8000, 32767, 0, 0, 32767, 0, 16'h8000);
      send_request(0, 0, 0, 1, 1, 2, 3);
      send_request(0, 0, 16'hffff, 0, 16'hffff, 1, 16'hffff);
      send_request(1000, 30000, 0, 0, 32767, 32767, 0);
      send_request(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
   endtask

   task automatic test_random(input int count);
      int qm;
      int vm;
      for (int i = 0; i < count; i++) begin
         qm = $urandom_range(3);
         vm = $urandom_range(2);
         if ($urandom_range(19) == 0)
            send_request(0, 0, 0, 0, pick_value(vm), pick_value(vm), pick_value(vm));
         else
            send_request(pick_value(qm), pick_value(qm), pick_value(qm), pick_value(qm),
                         pick_value(vm), pick_value(vm), pick_value(vm));
      end
   endtask

   task automatic test_back_pressure();
      hold_rsp = 1'b1;
      test_random(60);
   endtask

   task automatic test_full_rate();
      quiet = 1'b1;
      test_random(120);
      quiet = 1'b0;
   endtask

   initial begin
      errors     = 0;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(250);
      test_back_pressure();
      test_full_rate();
      test_random(220);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rotations_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
